// File: design/ps2dl_pkg.sv
// Shared types and constants for the PS/2 device-side link.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ps2dl_pkg;

  // Host and device line bits
  localparam logic [1:0] LINE_CLK  = 2'b01;
  localparam logic [1:0] LINE_DATA = 2'b10;
  localparam logic [1:0] LINE_BOTH = 2'b11;
  localparam logic [1:0] LINE_NONE = 2'b00;

  // Hold period register
  localparam int unsigned HOLD_W = 12;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 12'd200;
  localparam logic [HOLD_W-1:0] HOLD_MIN   = 12'd16;
  localparam int unsigned ACCUM_W = 13;

  // Register map (index = byte address / 4)
  localparam logic REG_HOLD_PERIOD = 1'b0;

  // Input kinds carried on tuser
  localparam logic OP_TIME = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  // Frame layout: start, eight data bits, parity, stop
  localparam int unsigned FRAME_W = 11;
  localparam logic [3:0] FRAME_LAST_BIT = 4'd10;
  localparam int unsigned LEVEL_W = 6;

  typedef enum logic [1:0] {
    MODE_DETECT,
    MODE_INHIBITED,
    MODE_RECEIVING,
    MODE_SENDING
  } link_mode_e;

  typedef enum logic [2:0] {
    PH_READY,
    PH_SEND_LO,
    PH_SEND_HI,
    PH_RECV_HI,
    PH_RECV_LO
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_POP,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept_push;
    logic accept_time;
    logic run_phase;
    logic finish_pop;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic accum_ge_hold;
    logic pop_req;
    logic slot_free;
  } dp_status_t;

endpackage

// File: design/ps2dl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the transmit FIFO bytes.
`timescale 1ns / 1ps

module ps2dl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ps2dl_ctrl.sv
// Sequencer for the PS/2 device-side link: accepts beats, loops hold phases,
// hands the result beat over. Depends on ps2dl_pkg.
`timescale 1ns / 1ps

module ps2dl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_op_i,
  output logic                  in_ready_o,
  input  ps2dl_pkg::dp_status_t stat_i,
  output ps2dl_pkg::ctrl_cmd_t  cmd_o
);
  import ps2dl_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_PUSH) begin
            cmd_o.accept_push = 1'b1;
            state_d = ST_EMIT;
          end else begin
            cmd_o.accept_time = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // one hold phase per cycle while the accumulator covers a period, except where a FIFO pop intervenes
        if (stat_i.accum_ge_hold) begin
          cmd_o.run_phase = 1'b1;
          if (stat_i.pop_req) begin
            state_d = ST_POP;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_POP: begin
        cmd_o.finish_pop = 1'b1;
        state_d = ST_RUN;
      end
      ST_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

endmodule

// File: design/ps2dl_datapath.sv
// Datapath of the PS/2 device-side link: link state, phase logic, transmit
// FIFO (on ps2dl_ram) and the result register. Depends on ps2dl_pkg.
`timescale 1ns / 1ps

module ps2dl_datapath #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ps2dl_pkg::ctrl_cmd_t          cmd_i,
  output ps2dl_pkg::dp_status_t         stat_o,
  input  logic [ps2dl_pkg::HOLD_W-1:0]  hold_period_i,
  input  logic [7:0]                    elapsed_i,
  input  logic [1:0]                    line_in_i,
  input  logic [7:0]                    tx_byte_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    line_out_o,
  output logic                          rx_valid_o,
  output logic [7:0]                    rx_byte_o,
  output logic                          rx_parity_ok_o,
  output logic                          rx_stop_ok_o,
  output logic [ps2dl_pkg::LEVEL_W-1:0] fifo_level_o,
  output logic                          push_dropped_o
);
  import ps2dl_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  // Link state
  link_mode_e           mode_q;
  phase_e               phase_q;
  logic [FRAME_W-1:0]   frame_q;
  logic [3:0]           bit_q;
  logic [ACCUM_W-1:0]   accum_q;
  logic [1:0]           drive_q;
  logic [1:0]           line_q;
  logic [AW-1:0]        head_q;
  logic [CW-1:0]        count_q;

  // Per-item results
  logic                 done_q;
  logic [7:0]           rxb_q;
  logic                 par_q;
  logic                 stop_q;
  logic                 dropped_q;

  // Result register
  logic                 out_valid_q;
  logic [1:0]           o_line_q;
  logic                 o_rxv_q;
  logic [7:0]           o_rxb_q;
  logic                 o_par_q;
  logic                 o_stop_q;
  logic [LEVEL_W-1:0]   o_level_q;
  logic                 o_drop_q;

  // Phase outcome
  link_mode_e           mode_n;
  phase_e               phase_n;
  logic [FRAME_W-1:0]   frame_n;
  logic [3:0]           bit_n;
  logic [1:0]           drive_n;
  logic                 done_n;
  logic                 pop_req;

  logic [HOLD_W-1:0]    hold_eff;
  logic                 accum_ge;
  logic                 fifo_full;
  logic [AW:0]          wr_sum;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        head_inc;
  logic [7:0]           pop_byte;
  logic                 ram_we;

  // Clamp the hold period and compare against the accumulator
  assign hold_eff = (hold_period_i < HOLD_MIN) ? HOLD_MIN : hold_period_i;
  assign accum_ge = accum_q >= ACCUM_W'(hold_eff);

  // FIFO pointers
  assign fifo_full = count_q >= CW'(FIFO_DEPTH);
  assign wr_sum    = (AW+1)'(head_q) + (AW+1)'(count_q);
  assign wr_addr   = (wr_sum >= (AW+1)'(FIFO_DEPTH)) ? AW'(wr_sum - (AW+1)'(FIFO_DEPTH))
                                                     : AW'(wr_sum);
  assign head_inc  = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign ram_we    = cmd_i.accept_push & ~fifo_full;

  ps2dl_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (tx_byte_i),
    .re_i    (cmd_i.run_phase),
    .raddr_i (head_q),
    .rdata_o (pop_byte)
  );

  // One hold phase: line detection, then half a clock period of activity
  always_comb begin
    mode_n  = mode_q;
    phase_n = phase_q;
    frame_n = frame_q;
    bit_n   = bit_q;
    drive_n = drive_q;
    done_n  = 1'b0;
    pop_req = 1'b0;

    if (mode_q == MODE_DETECT || mode_q == MODE_INHIBITED) begin
      if (line_q == LINE_CLK) begin
        // host request-to-send
        mode_n  = MODE_RECEIVING;
        phase_n = PH_RECV_LO;
        bit_n   = '0;
        frame_n = '0;
      end else if (line_q == LINE_BOTH) begin
        frame_n = '0;
        mode_n  = MODE_SENDING;
        phase_n = PH_READY;
      end else begin
        mode_n  = MODE_INHIBITED;
      end
    end

    unique case (mode_n)
      MODE_INHIBITED: begin
        drive_n = LINE_BOTH;
      end
      MODE_RECEIVING: begin
        if (phase_n == PH_RECV_HI) begin
          if (bit_n >= FRAME_LAST_BIT) begin
            drive_n = LINE_BOTH;
            mode_n  = MODE_DETECT;
          end else begin
            if (line_q[1]) begin
              frame_n[bit_n] = 1'b1;
            end
            drive_n = LINE_BOTH;
            phase_n = PH_RECV_LO;
            bit_n   = bit_n + 1'b1;
          end
        end else if (phase_n == PH_RECV_LO) begin
          if (bit_n >= FRAME_LAST_BIT) begin
            done_n  = 1'b1;
            drive_n = LINE_NONE;
          end else begin
            drive_n = LINE_DATA;
          end
          phase_n = PH_RECV_HI;
        end
      end
      MODE_SENDING: begin
        unique case (phase_n)
          PH_READY: begin
            if (count_q == '0) begin
              drive_n = LINE_CLK;
            end else begin
              // byte load completes in the following cycle
              pop_req = 1'b1;
            end
          end
          PH_SEND_LO: begin
            drive_n = frame_n[0] ? LINE_DATA : LINE_NONE;
            frame_n = frame_n >> 1;
            phase_n = PH_SEND_HI;
          end
          PH_SEND_HI: begin
            drive_n = drive_n | LINE_CLK;
            if (frame_n != '0) begin
              phase_n = PH_SEND_LO;
            end else begin
              mode_n  = MODE_DETECT;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_DETECT: begin
      end
    endcase
  end

  // Link state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_DETECT;
      phase_q <= PH_READY;
      frame_q <= '0;
      bit_q   <= '0;
      accum_q <= '0;
      drive_q <= '0;
      line_q  <= '0;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.accept_time) begin
        accum_q <= accum_q + ACCUM_W'(elapsed_i);
        line_q  <= line_in_i;
      end
      if (ram_we) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.run_phase) begin
        accum_q <= accum_q - ACCUM_W'(hold_eff);
        mode_q  <= mode_n;
        phase_q <= phase_n;
        frame_q <= frame_n;
        bit_q   <= bit_n;
        drive_q <= drive_n;
      end
      if (cmd_i.finish_pop) begin
        // start 0, data LSB first, odd parity, stop 1
        frame_q <= {1'b1, ~^pop_byte, pop_byte, 1'b0};
        phase_q <= PH_SEND_LO;
        head_q  <= head_inc;
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Per-item receive and drop results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      rxb_q     <= '0;
      par_q     <= 1'b0;
      stop_q    <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      if (cmd_i.accept_time || cmd_i.accept_push) begin
        done_q    <= 1'b0;
        rxb_q     <= '0;
        par_q     <= 1'b0;
        stop_q    <= 1'b0;
        dropped_q <= cmd_i.accept_push & fifo_full;
      end
      if (cmd_i.run_phase && done_n) begin
        done_q <= 1'b1;
        rxb_q  <= frame_n[7:0];
        par_q  <= ^frame_n[8:0];
        stop_q <= frame_n[9];
      end
    end
  end

  // Result register: load on emit, drop on downstream take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      o_line_q  <= drive_q;
      o_rxv_q   <= done_q;
      o_rxb_q   <= rxb_q;
      o_par_q   <= par_q;
      o_stop_q  <= stop_q;
      o_level_q <= LEVEL_W'(count_q);
      o_drop_q  <= dropped_q;
    end
  end

  assign stat_o.accum_ge_hold = accum_ge;
  assign stat_o.pop_req       = pop_req;
  assign stat_o.slot_free     = ~out_valid_q | out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign line_out_o     = o_line_q;
  assign rx_valid_o     = o_rxv_q;
  assign rx_byte_o      = o_rxb_q;
  assign rx_parity_ok_o = o_par_q;
  assign rx_stop_ok_o   = o_stop_q;
  assign fifo_level_o   = o_level_q;
  assign push_dropped_o = o_drop_q;

endmodule

// File: design/ps2_device_side_link.sv
// Top level of the PS/2 device-side link: stream ports, APB register,
// controller and datapath. Depends on ps2dl_pkg, ps2dl_ctrl, ps2dl_datapath.
//
//  channel  | direction | beat contents
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tuser: operation; tdata: elapsed, line_in, tx_byte
//  m_axis   | out       | tdata: line_out, rx_valid, rx_byte, rx_parity_ok,
//           |           |        rx_stop_ok, fifo_level, push_dropped
//  apb      | in/out    | hold_period at byte address 0
//
// One beat is worked at a time. A push beat passes through EMIT to its result.
// A time beat runs hold phases in the phase loop while the accumulator covers
// the hold period, each FIFO pop adding a RAM read, and ends once the
// accumulator is found below the hold period.
// The result register lets the next beat enter while a result is still held.
// Reset leaves the FIFO RAM uncleared; no clearing pass is needed.
`timescale 1ns / 1ps

module ps2_device_side_link #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // elapsed[7:0], line_in[9:8], tx_byte[17:10], zero pad
  input  logic        s_axis_tuser,  // operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // line_out[1:0], rx_valid[2], rx_byte[10:3],
                                     // rx_parity_ok[11], rx_stop_ok[12],
                                     // fifo_level[18:13], push_dropped[19], zero pad
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ps2dl_pkg::*;

  logic [HOLD_W-1:0]  hold_q;
  logic               reg_sel;
  ctrl_cmd_t          cmd;
  dp_status_t         stat;

  logic [1:0]         line_out;
  logic               rx_valid;
  logic [7:0]         rx_byte;
  logic               rx_parity_ok;
  logic               rx_stop_ok;
  logic [LEVEL_W-1:0] fifo_level;
  logic               push_dropped;

  // APB register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_HOLD_PERIOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      hold_q <= pwdata[HOLD_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32-HOLD_W){1'b0}}, hold_q} : '0;

  ps2dl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ps2dl_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .hold_period_i  (hold_q),
    .elapsed_i      (s_axis_tdata[7:0]),
    .line_in_i      (s_axis_tdata[9:8]),
    .tx_byte_i      (s_axis_tdata[17:10]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .line_out_o     (line_out),
    .rx_valid_o     (rx_valid),
    .rx_byte_o      (rx_byte),
    .rx_parity_ok_o (rx_parity_ok),
    .rx_stop_ok_o   (rx_stop_ok),
    .fifo_level_o   (fifo_level),
    .push_dropped_o (push_dropped)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'b0000, push_dropped, fifo_level, rx_stop_ok, rx_parity_ok,
                         rx_byte, rx_valid, line_out};

endmodule
